// ===== sv/cbct_pkg.sv =====
// ----------------------------------------------------------------------------
// cbct_pkg - shared types and constants of the blob centroid tracker
// Command and register codes, config widths and resets, front/back control.
// ----------------------------------------------------------------------------
`default_nettype none

package cbct_pkg;

  localparam int COLOR_W    = 8;
  localparam int MARGIN_W   = 8;
  localparam int MIN_W      = 10;
  localparam int START_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(20);
  localparam logic [MIN_W-1:0]    MIN_RST    = MIN_W'(10);

  typedef enum logic [1:0] {
    CMD_CENTER  = 2'd0,
    CMD_ONE     = 2'd1,
    CMD_TWO     = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARGIN      = 3'd0,
    REG_MIN_COUNT   = 3'd1,
    REG_START_ONE_X = 3'd2,
    REG_START_ONE_Y = 3'd3,
    REG_START_TWO_X = 3'd4,
    REG_START_TWO_Y = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // classified item passed from front to back
  typedef struct packed {
    cmd_t cmd;
    logic keep;        // ring sample matches current mode
    logic blue_lead;   // center sample: blue dominant
    logic green_lead;  // center sample: green dominant
    logic last;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  typedef struct packed {
    logic [MIN_W-1:0]   min_count;
    logic [START_W-1:0] start_one_x;
    logic [START_W-1:0] start_one_y;
    logic [START_W-1:0] start_two_x;
    logic [START_W-1:0] start_two_y;
  } back_cfg_t;

endpackage

`default_nettype wire

// ===== sv/cbct_if.sv =====
// ----------------------------------------------------------------------------
// cbct_if - channel interfaces of the blob centroid tracker
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbct_in_if #(parameter int COORD_BITS = 12);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [cbct_pkg::COLOR_W-1:0]   red;
  logic [cbct_pkg::COLOR_W-1:0]   green;
  logic [cbct_pkg::COLOR_W-1:0]   blue;
  logic [COORD_BITS-1:0]          sample_x;
  logic [COORD_BITS-1:0]          sample_y;
  logic                           last;

  modport source (output valid, command, red, green, blue, sample_x, sample_y, last,
                  input ready);
  modport sink (input valid, command, red, green, blue, sample_x, sample_y, last,
                output ready);
endinterface

interface cbct_out_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  target;
  logic [COORD_BITS-1:0] position_x;
  logic [COORD_BITS-1:0] position_y;
  logic                  found;
  logic                  is_green;

  modport source (output valid, target, position_x, position_y, found, is_green,
                  input ready);
  modport sink (input valid, target, position_x, position_y, found, is_green,
                output ready);
endinterface

interface cbct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cbct_pkg::CFG_IDX_W-1:0]  index;
  logic [cbct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/cbct_front.sv =====
// ----------------------------------------------------------------------------
// cbct_front - sample classifier
// Tracks the frame color mode and marks ring samples that match it.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [cbct_pkg::MARGIN_W-1:0] color_margin,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_command,
  input  wire logic [cbct_pkg::COLOR_W-1:0]  in_red,
  input  wire logic [cbct_pkg::COLOR_W-1:0]  in_green,
  input  wire logic [cbct_pkg::COLOR_W-1:0]  in_blue,
  input  wire logic                          in_last,
  output logic                               q_push,
  input  wire logic                          q_ready,
  output cbct_pkg::ctl_t                     q_ctl
);
  import cbct_pkg::*;

  logic blue_mode_r, blue_mode_nxt;
  logic blue_lead, green_lead, accept;
  cmd_t cmd;

  // lead - other > margin, as lead > other + margin
  function automatic logic leads(input logic [COLOR_W-1:0] lead,
                                 input logic [COLOR_W-1:0] a,
                                 input logic [COLOR_W-1:0] b,
                                 input logic [MARGIN_W-1:0] m);
    logic [COLOR_W:0] la, lb, ll;
    begin
      la = {1'b0, a} + {1'b0, m};
      lb = {1'b0, b} + {1'b0, m};
      ll = {1'b0, lead};
      leads = (ll > la) && (ll > lb);
    end
  endfunction

  assign cmd        = cmd_t'(in_command);
  assign blue_lead  = leads(in_blue, in_red, in_green, color_margin);
  assign green_lead = leads(in_green, in_blue, in_red, color_margin);
  assign in_ready   = q_ready;
  assign q_push     = in_valid;
  assign accept     = in_valid && q_ready;

  always_comb begin
    q_ctl.cmd        = cmd;
    q_ctl.keep       = blue_mode_r ? blue_lead : green_lead;
    q_ctl.blue_lead  = blue_lead;
    q_ctl.green_lead = green_lead;
    q_ctl.last       = in_last;
    blue_mode_nxt    = blue_mode_r;
    if (accept) begin
      unique case (cmd)
        CMD_CENTER:  blue_mode_nxt = blue_lead;
        CMD_RESTART: blue_mode_nxt = 1'b0;
        default:     blue_mode_nxt = blue_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_mode_r <= 1'b0;
    end else begin
      blue_mode_r <= blue_mode_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbct_fifo.sv =====
// ----------------------------------------------------------------------------
// cbct_fifo - small item queue
// Register-based FIFO between classifier and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] din,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign dout       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbct_div.sv =====
// ----------------------------------------------------------------------------
// cbct_div - restoring divider
// One quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);
  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    rem_r, rem_sh, rem_sub;
  logic [DIVISOR_W-1:0]  div_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r, done_r, ge;

  assign rem_sh   = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? rem_sub : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbct_back.sv =====
// ----------------------------------------------------------------------------
// cbct_back - accumulator and position update
// Sums kept ring samples, divides at the last when found, issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_back #(
  parameter int COORD_BITS  = 12,
  parameter int MAX_SAMPLES = 1023
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cbct_pkg::back_cfg_t   cfg,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire cbct_pkg::ctl_t        q_ctl,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_target,
  output logic [COORD_BITS-1:0]      out_position_x,
  output logic [COORD_BITS-1:0]      out_position_y,
  output logic                       out_found,
  output logic                       out_is_green
);
  import cbct_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = COORD_BITS + CNT_W;
  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  back_state_t           st_r, st_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt, cnt_add;
  logic [SUM_W-1:0]      sum_x_r, sum_x_nxt, sum_x_add;
  logic [SUM_W-1:0]      sum_y_r, sum_y_nxt, sum_y_add;
  logic [COORD_BITS-1:0] p1x_r, p1x_nxt, p1y_r, p1y_nxt;
  logic [COORD_BITS-1:0] p2x_r, p2x_nxt, p2y_r, p2y_nxt;
  logic                  green_r, green_nxt;
  logic                  tgt_r, tgt_nxt, found_r, found_nxt;
  logic                  ov_r, ov_nxt;
  logic                  o_tgt_r, o_found_r, o_green_r;
  logic [COORD_BITS-1:0] o_x_r, o_y_r;
  logic                  load_out, keep_ok, found_now, div_start;
  logic                  done_x, done_y;
  logic [SUM_W-1:0]      quo_x, quo_y;

  assign keep_ok   = q_ctl.keep && (cnt_r < CNT_W'(MAX_SAMPLES));
  assign cnt_add   = keep_ok ? cnt_r + 1'b1 : cnt_r;
  assign sum_x_add = keep_ok ? sum_x_r + SUM_W'(q_x) : sum_x_r;
  assign sum_y_add = keep_ok ? sum_y_r + SUM_W'(q_y) : sum_y_r;
  assign found_now = CMP_W'(cnt_add) > CMP_W'(cfg.min_count);

  cbct_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_x_add),
    .divisor(cnt_add), .done(done_x), .quotient(quo_x)
  );

  cbct_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_y_add),
    .divisor(cnt_add), .done(done_y), .quotient(quo_y)
  );

  assign out_valid      = ov_r;
  assign out_target     = o_tgt_r;
  assign out_position_x = o_x_r;
  assign out_position_y = o_y_r;
  assign out_found      = o_found_r;
  assign out_is_green   = o_green_r;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    p1x_nxt   = p1x_r;
    p1y_nxt   = p1y_r;
    p2x_nxt   = p2x_r;
    p2y_nxt   = p2y_r;
    green_nxt = green_r;
    tgt_nxt   = tgt_r;
    found_nxt = found_r;
    ov_nxt    = ov_r && !out_ready;
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (st_r)
      BK_RUN: begin
        q_pop = 1'b1;
        if (q_valid) begin
          unique case (q_ctl.cmd)
            CMD_RESTART: begin
              p1x_nxt   = COORD_BITS'(cfg.start_one_x);
              p1y_nxt   = COORD_BITS'(cfg.start_one_y);
              p2x_nxt   = COORD_BITS'(cfg.start_two_x);
              p2y_nxt   = COORD_BITS'(cfg.start_two_y);
              green_nxt = 1'b0;
              cnt_nxt   = '0;
              sum_x_nxt = '0;
              sum_y_nxt = '0;
            end
            CMD_CENTER: begin
              if (q_ctl.blue_lead) begin
                green_nxt = 1'b0;
              end else if (q_ctl.green_lead) begin
                green_nxt = 1'b1;
              end
              cnt_nxt   = '0;
              sum_x_nxt = '0;
              sum_y_nxt = '0;
            end
            default: begin
              if (q_ctl.last) begin
                tgt_nxt   = (q_ctl.cmd == CMD_TWO);
                found_nxt = found_now;
                cnt_nxt   = '0;
                sum_x_nxt = '0;
                sum_y_nxt = '0;
                if (found_now) begin
                  div_start = 1'b1;
                  st_nxt    = BK_DIV;
                end else begin
                  green_nxt = 1'b0;
                  st_nxt    = BK_OUT;
                end
              end else begin
                cnt_nxt   = cnt_add;
                sum_x_nxt = sum_x_add;
                sum_y_nxt = sum_y_add;
              end
            end
          endcase
        end
      end
      BK_DIV: begin
        if (done_x && done_y) begin
          if (tgt_r) begin
            p2x_nxt = quo_x[COORD_BITS-1:0];
            p2y_nxt = quo_y[COORD_BITS-1:0];
          end else begin
            p1x_nxt = quo_x[COORD_BITS-1:0];
            p1y_nxt = quo_y[COORD_BITS-1:0];
          end
          st_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!ov_r || out_ready) begin
          load_out = 1'b1;
          ov_nxt   = 1'b1;
          st_nxt   = BK_RUN;
        end
      end
      default: st_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_RUN;
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      p1x_r   <= '0;
      p1y_r   <= '0;
      p2x_r   <= '0;
      p2y_r   <= '0;
      green_r <= 1'b0;
      tgt_r   <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      p1x_r   <= p1x_nxt;
      p1y_r   <= p1y_nxt;
      p2x_r   <= p2x_nxt;
      p2y_r   <= p2y_nxt;
      green_r <= green_nxt;
      tgt_r   <= tgt_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_tgt_r   <= tgt_r;
      o_found_r <= found_r;
      o_green_r <= green_r;
      o_x_r     <= tgt_r ? p2x_r : p1x_r;
      o_y_r     <= tgt_r ? p2y_r : p1y_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/color_blob_centroid_tracker.sv =====
// ----------------------------------------------------------------------------
// color_blob_centroid_tracker - two-target colored blob tracker
// Classifies samples by frame color mode and moves each target to the
// truncated mean of its matching ring samples when more than min_count match.
//
//   channel  | dir | handshake     | item
//   in_ch    | in  | valid/ready   | command, red, green, blue, sample_x/y, last
//   out_ch   | out | valid/ready   | target, position_x/y, found, is_green
//   cfg_ch   | in  | valid/ready   | index, data (ready always high)
//
// Center, restart and non-last ring items are taken by the back end in its run state.
// A last ring item sends the back end to its output state when the target stays,
// and through a bit-serial divide first when it moves, taking no item meanwhile.
// A 4-entry queue lets the classifier accept while the back end divides or the
// result register waits. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module color_blob_centroid_tracker #(
  parameter int COORD_BITS  = 12,
  parameter int MAX_SAMPLES = 1023
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbct_in_if.sink     in_ch,
  cbct_out_if.source  out_ch,
  cbct_cfg_if.sink    cfg_ch
);
  import cbct_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_W     = CTL_W + 2 * COORD_BITS;

  logic [MARGIN_W-1:0] margin_r;
  back_cfg_t           bcfg_r;
  ctl_t                f_ctl, b_ctl;
  logic                f_push, q_ready, q_valid, q_pop;
  logic [Q_W-1:0]      q_din, q_dout;
  logic [COORD_BITS-1:0] b_x, b_y;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r           <= MARGIN_RST;
      bcfg_r.min_count   <= MIN_RST;
      bcfg_r.start_one_x <= '0;
      bcfg_r.start_one_y <= '0;
      bcfg_r.start_two_x <= '0;
      bcfg_r.start_two_y <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MARGIN:      margin_r           <= cfg_ch.data[MARGIN_W-1:0];
        REG_MIN_COUNT:   bcfg_r.min_count   <= cfg_ch.data[MIN_W-1:0];
        REG_START_ONE_X: bcfg_r.start_one_x <= cfg_ch.data[START_W-1:0];
        REG_START_ONE_Y: bcfg_r.start_one_y <= cfg_ch.data[START_W-1:0];
        REG_START_TWO_X: bcfg_r.start_two_x <= cfg_ch.data[START_W-1:0];
        REG_START_TWO_Y: bcfg_r.start_two_y <= cfg_ch.data[START_W-1:0];
        default: ;
      endcase
    end
  end

  cbct_front u_front (
    .clk(clk), .rst_n(rst_n), .color_margin(margin_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_red(in_ch.red), .in_green(in_ch.green),
    .in_blue(in_ch.blue), .in_last(in_ch.last),
    .q_push(f_push), .q_ready(q_ready), .q_ctl(f_ctl)
  );

  assign q_din = {f_ctl, in_ch.sample_x, in_ch.sample_y};

  cbct_fifo #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_push), .push_ready(q_ready), .din(q_din),
    .pop_valid(q_valid), .pop(q_pop), .dout(q_dout)
  );

  assign b_ctl = ctl_t'(q_dout[Q_W-1 -: CTL_W]);
  assign b_x   = q_dout[2*COORD_BITS-1 -: COORD_BITS];
  assign b_y   = q_dout[COORD_BITS-1:0];

  cbct_back #(.COORD_BITS(COORD_BITS), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(bcfg_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_ctl(b_ctl), .q_x(b_x), .q_y(b_y),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_target(out_ch.target), .out_position_x(out_ch.position_x),
    .out_position_y(out_ch.position_y), .out_found(out_ch.found),
    .out_is_green(out_ch.is_green)
  );

endmodule

`default_nettype wire

// ===== bench/centroid_checker.sv =====
// ----------------------------------------------------------------------------
// centroid_checker - result checker for the blob centroid tracker
// Watches the sample, result and register channels, keeps its own copy of
// the tracker state, works out each target update and compares it field by
// field with what the block sends. Counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module centroid_checker #(
  parameter int COORD_BITS  = 12,
  parameter int MAX_SAMPLES = 1023
) (
  input  logic clk,
  input  logic rst_n,
  cbct_in_if   in_ch,
  cbct_out_if  out_ch,
  cbct_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   updates,
  output int   moves
);
  import cbct_pkg::*;

  typedef struct packed {
    logic                  target;
    logic [COORD_BITS-1:0] position_x;
    logic [COORD_BITS-1:0] position_y;
    logic                  found;
    logic                  is_green;
  } track_update_t;

  track_update_t expected_updates[$];

  logic [MARGIN_W-1:0]   margin;
  logic [MIN_W-1:0]      min_kept;
  logic [COORD_BITS-1:0] start_one_x, start_one_y, start_two_x, start_two_y;
  logic [COORD_BITS-1:0] one_x, one_y, two_x, two_y;
  bit                    blue_mode, green_seen;
  int                    kept, sum_x, sum_y;
  int                    errors, update_count, move_count;

  function automatic bit leads(int lead, int a, int b);
    return (lead - a) > int'(margin) && (lead - b) > int'(margin);
  endfunction

  task automatic clear_sums();
    kept  = 0;
    sum_x = 0;
    sum_y = 0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MARGIN:      margin      = data[MARGIN_W-1:0];
      REG_MIN_COUNT:   min_kept    = data[MIN_W-1:0];
      REG_START_ONE_X: start_one_x = COORD_BITS'(data);
      REG_START_ONE_Y: start_one_y = COORD_BITS'(data);
      REG_START_TWO_X: start_two_x = COORD_BITS'(data);
      REG_START_TWO_Y: start_two_y = COORD_BITS'(data);
      default: ;
    endcase
  endtask

  task automatic track_sample(cmd_t cmd, int red, int green, int blue, int x, int y,
                              bit last);
    bit            keep;
    track_update_t upd;
    case (cmd)
      CMD_RESTART: begin
        one_x      = start_one_x;
        one_y      = start_one_y;
        two_x      = start_two_x;
        two_y      = start_two_y;
        blue_mode  = 1'b0;
        green_seen = 1'b0;
        clear_sums();
      end
      CMD_CENTER: begin
        if (leads(blue, red, green)) begin
          blue_mode  = 1'b1;
          green_seen = 1'b0;
        end else if (leads(green, blue, red)) begin
          blue_mode  = 1'b0;
          green_seen = 1'b1;
        end else begin
          blue_mode = 1'b0;
        end
        clear_sums();
      end
      default: begin
        keep = blue_mode ? leads(blue, red, green) : leads(green, blue, red);
        if (keep && kept < MAX_SAMPLES) begin
          kept++;
          sum_x += x;
          sum_y += y;
        end
        if (last) begin
          upd.found = (kept > int'(min_kept));
          if (upd.found) begin
            if (cmd == CMD_ONE) begin
              one_x = COORD_BITS'(sum_x / kept);
              one_y = COORD_BITS'(sum_y / kept);
            end else begin
              two_x = COORD_BITS'(sum_x / kept);
              two_y = COORD_BITS'(sum_y / kept);
            end
          end else begin
            green_seen = 1'b0;
          end
          upd.target     = (cmd == CMD_TWO);
          upd.position_x = (cmd == CMD_ONE) ? one_x : two_x;
          upd.position_y = (cmd == CMD_ONE) ? one_y : two_y;
          upd.is_green   = green_seen;
          expected_updates.insert(expected_updates.size(), upd);
          clear_sums();
        end
      end
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    track_update_t want;
    if (!rst_n) begin
      margin      = MARGIN_RST;
      min_kept    = MIN_RST;
      start_one_x = '0;
      start_one_y = '0;
      start_two_x = '0;
      start_two_y = '0;
      one_x       = '0;
      one_y       = '0;
      two_x       = '0;
      two_y       = '0;
      blue_mode   = 1'b0;
      green_seen  = 1'b0;
      clear_sums();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        write_reg(reg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        track_sample(cmd_t'(in_ch.command), in_ch.red, in_ch.green, in_ch.blue,
                     in_ch.sample_x, in_ch.sample_y, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: expected none, actual target %0d pos (%0d,%0d) found %0d green %0d",
                   $time, out_ch.target, out_ch.position_x, out_ch.position_y,
                   out_ch.found, out_ch.is_green);
        end else begin
          want = expected_updates.pop_front();
          check_field("target", want.target, out_ch.target);
          check_field("position_x", want.position_x, out_ch.position_x);
          check_field("position_y", want.position_y, out_ch.position_y);
          check_field("found", want.found, out_ch.found);
          check_field("is_green", want.is_green, out_ch.is_green);
          update_count++;
          if (want.found)
            move_count++;
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_updates.size();
    updates    <= update_count;
    moves      <= move_count;
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - top level for the blob centroid tracker
// Drives frames of center and ring samples with random gaps and result
// stalls, steps through several register settings (extremes included),
// runs one saturating ring, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cbct_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int MAX_SAMPLES   = 1023;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int SAT_LEN       = 1030;
  localparam int ITEM_GOAL     = 1425;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ANY   = 3;

  logic clk;
  logic rst_n;

  cbct_in_if #(.COORD_BITS(COORD_BITS))  in_ch();
  cbct_out_if #(.COORD_BITS(COORD_BITS)) out_ch();
  cbct_cfg_if                            cfg_ch();

  int fail_count, pending, updates, moves;
  int items_sent, settings_used, quiet_cycles, ready_hold;
  int margin_now, min_now;
  bit calm;

  color_blob_centroid_tracker #(
    .COORD_BITS (COORD_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  centroid_checker #(
    .COORD_BITS (COORD_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) tracker_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .updates   (updates),
    .moves     (moves)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : result_stall
    int hold;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold   <= ready_hold - 1;
      out_ch.ready <= (ready_hold == 1);
    end else if (out_ch.valid && out_ch.ready) begin
      hold = calm ? 0 : $urandom_range(0, 4);
      ready_hold   <= hold;
      out_ch.ready <= (hold == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(cmd_t c, logic [23:0] rgb, logic [COORD_BITS-1:0] x,
                           logic [COORD_BITS-1:0] y, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= c;
    {in_ch.red, in_ch.green, in_ch.blue} <= rgb;
    in_ch.sample_x <= x;
    in_ch.sample_y <= y;
    in_ch.last     <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(int margin, int minc, int s1x, int s1y, int s2x, int s2y);
    logic [CFG_DATA_W-1:0] vals[6];
    reg_idx_t              order[6];
    wait_idle();
    order = '{REG_MARGIN, REG_MIN_COUNT, REG_START_ONE_X, REG_START_ONE_Y,
              REG_START_TWO_X, REG_START_TWO_Y};
    // unused upper data bits carry junk
    vals[0] = {4'($urandom), 8'(margin)};
    vals[1] = {2'($urandom), 10'(minc)};
    vals[2] = 12'(s1x);
    vals[3] = 12'(s1y);
    vals[4] = 12'(s2x);
    vals[5] = 12'(s2y);
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_ch.index <= order[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    margin_now = margin;
    min_now    = minc;
    settings_used++;
  endtask

  // {red, green, blue} with one channel margin or more above both others
  function automatic logic [23:0] make_pixel(int lead, bit at_limit);
    int ch[3];
    int base;
    if (lead == CH_ANY || margin_now >= 255)
      return 24'($urandom);
    ch[0] = $urandom_range(0, 254 - margin_now);
    ch[1] = $urandom_range(0, 254 - margin_now);
    ch[2] = $urandom_range(0, 254 - margin_now);
    base  = (ch[(lead + 1) % 3] > ch[(lead + 2) % 3]) ? ch[(lead + 1) % 3]
                                                       : ch[(lead + 2) % 3];
    ch[lead] = at_limit ? base + margin_now : $urandom_range(base + margin_now + 1, 255);
    return {8'(ch[0]), 8'(ch[1]), 8'(ch[2])};
  endfunction

  function automatic logic [COORD_BITS-1:0] near(int center, int spread);
    int v;
    v = center - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0)
      v = 0;
    if (v > COORD_MAX)
      v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  task automatic run_ring(cmd_t tgt, int match_ch);
    int          len, hi, cx, cy, spread, other_ch;
    cmd_t        other_tgt, c;
    logic [23:0] pix;
    hi        = (min_now < 12) ? min_now + 8 : 20;
    len       = $urandom_range(1, hi);
    cx        = $urandom_range(0, COORD_MAX);
    cy        = $urandom_range(0, COORD_MAX);
    spread    = $urandom_range(0, 300);
    other_ch  = (match_ch == CH_BLUE) ? CH_GREEN : CH_BLUE;
    other_tgt = (tgt == CMD_ONE) ? CMD_TWO : CMD_ONE;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       pix = make_pixel(match_ch, 1'b1);
        1:       pix = make_pixel(CH_ANY, 1'b0);
        2:       pix = make_pixel($urandom_range(0, 1) ? CH_RED : other_ch, 1'b0);
        default: pix = make_pixel(match_ch, 1'b0);
      endcase
      c = (i != len - 1 && $urandom_range(0, 19) == 0) ? other_tgt : tgt;
      if ($urandom_range(0, 7) == 0)
        send_item(c, pix, COORD_BITS'($urandom), COORD_BITS'($urandom), i == len - 1);
      else
        send_item(c, pix, near(cx, spread), near(cy, spread), i == len - 1);
    end
  endtask

  task automatic run_frame();
    int   kind, mode_ch, n;
    cmd_t first;
    kind = $urandom_range(0, 15);
    calm <= ($urandom_range(0, 5) == 0);
    if (kind == 0) begin
      send_item(CMD_RESTART, 24'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                1'($urandom));
    end else if (kind == 1) begin
      n = $urandom_range(1, 6);
      repeat (n)
        send_item(cmd_t'($urandom_range(CMD_CENTER, CMD_TWO)), 24'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0, 1:    mode_ch = CH_BLUE;
        2, 3:    mode_ch = CH_GREEN;
        4:       mode_ch = CH_RED;
        default: mode_ch = CH_ANY;
      endcase
      // kind 2: ring with no center sample ahead of it
      if (kind != 2)
        send_item(CMD_CENTER, make_pixel(mode_ch, $urandom_range(0, 7) == 0),
                  COORD_BITS'($urandom), COORD_BITS'($urandom), 1'($urandom));
      first = $urandom_range(0, 1) ? CMD_ONE : CMD_TWO;
      run_ring(first, (mode_ch == CH_BLUE) ? CH_BLUE : CH_GREEN);
      if ($urandom_range(0, 3) != 0)
        run_ring((first == CMD_ONE) ? CMD_TWO : CMD_ONE,
                 (mode_ch == CH_BLUE) ? CH_BLUE : CH_GREEN);
    end
  endtask

  task automatic run_frames(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count)
      run_frame();
  endtask

  task automatic run_directed();
    send_item(CMD_RESTART, 24'hFFFFFF, 12'hFFF, 12'hFFF, 1'b1);
    send_item(CMD_ONE, 24'hFFFFFF, 12'hFFF, 12'hFFF, 1'b1);
    send_item(CMD_CENTER, 24'h00FF00, 12'h000, 12'h000, 1'b0);
    for (int i = 0; i < 11; i++)
      send_item(CMD_ONE, 24'h00FF00, (i % 2) ? 12'hFFF : 12'h000,
                (i % 2) ? 12'h000 : 12'hFFF, i == 10);
    send_item(CMD_CENTER, 24'h0000FF, 12'h000, 12'h000, 1'b0);
    // blue lead equal to margin, then one above
    send_item(CMD_ONE, 24'h000014, 12'h123, 12'h456, 1'b0);
    send_item(CMD_ONE, 24'h000015, 12'h789, 12'hABC, 1'b0);
    send_item(CMD_CENTER, 24'h808080, 12'h000, 12'h000, 1'b0);
    send_item(CMD_TWO, 24'h00FF00, 12'h800, 12'h7FF, 1'b1);
    send_item(CMD_CENTER, 24'hEAFF00, 12'h000, 12'h000, 1'b0);
    send_item(CMD_ONE, 24'h00FF00, 12'd100, 12'd200, 1'b0);
    send_item(CMD_TWO, 24'h00FF00, 12'd300, 12'd400, 1'b1);
    send_item(CMD_CENTER, 24'h00FF00, 12'h000, 12'h000, 1'b0);
    send_item(CMD_RESTART, 24'h000000, 12'h000, 12'h000, 1'b0);
    send_item(CMD_CENTER, 24'h000000, 12'h000, 12'h000, 1'b0);
  endtask

  task automatic run_saturation();
    send_item(CMD_RESTART, 24'($urandom), 12'h000, 12'h000, 1'b0);
    send_item(CMD_CENTER, make_pixel(CH_GREEN, 1'b0), 12'h000, 12'h000, 1'b0);
    for (int i = 0; i < SAT_LEN; i++)
      send_item(CMD_TWO, make_pixel(CH_GREEN, 1'b0), COORD_BITS'($urandom),
                COORD_BITS'($urandom), i == SAT_LEN - 1);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_CENTER;
    in_ch.red      <= '0;
    in_ch.green    <= '0;
    in_ch.blue     <= '0;
    in_ch.sample_x <= '0;
    in_ch.sample_y <= '0;
    in_ch.last     <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_MARGIN;
    cfg_ch.data    <= '0;
    calm           <= 1'b0;
    margin_now    = MARGIN_RST;
    min_now       = MIN_RST;
    settings_used = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    apply_settings(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    run_frames(150);
    apply_settings(30, 1022, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    run_saturation();
    apply_settings(255, 1023, 0, 0, 0, 0);
    run_frames(80);
    while (items_sent < ITEM_GOAL && settings_used < 40) begin
      apply_settings($urandom_range(0, 60), $urandom_range(0, 12),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      run_frames(40);
    end

    wait_idle();
    $display("Sent %0d sample items under %0d register settings, one ring of %0d samples.",
             items_sent, settings_used, SAT_LEN);
    $display("Checked %0d target updates, %0d of which moved a target.", updates, moves);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== color_blob_centroid_tracker.f =====
sv/cbct_pkg.sv
sv/cbct_if.sv
sv/cbct_front.sv
sv/cbct_fifo.sv
sv/cbct_div.sv
sv/cbct_back.sv
sv/color_blob_centroid_tracker.sv
bench/centroid_checker.sv
bench/testbench.sv
